>>> rtl/tccw_pkg.sv
// shared types and constants for the text console cursor writer
package tccw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CALC_W = ROW_W + COL_W + 1;

    localparam logic [COL_W:0] COLS_EXT = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0] ROWS_EXT = (ROW_W + 1)'(ROWS);

    localparam logic [7:0] ATTR_TEXT   = 8'h0F;
    localparam logic [7:0] ATTR_BLANK  = 8'h07;
    localparam logic [7:0] CODE_BS     = 8'd8;
    localparam logic [7:0] CODE_NL     = 8'd10;
    localparam logic [7:0] CHAR_PROMPT = 8'h3E;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    localparam logic [COL_W-1:0] FLOOR_RESET = COL_W'(2);
    localparam logic [COL_W-1:0] COL_ONE     = COL_W'(1);
    localparam logic [COL_W-1:0] COL_TWO     = COL_W'(2);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int TDATA_W = 40;

    // one decoded request: optional main write, optional two-cell prompt
    typedef struct packed {
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] cur_col;
        logic [ROW_W-1:0] cur_line;
        logic             first;
        logic             prompt;
        logic [ROW_W-1:0] prow;
        logic             pclr;
    } cmd_t;

    typedef enum logic [2:0] {
        BEAT_MAIN = 3'b001,
        BEAT_GT   = 3'b010,
        BEAT_SP   = 3'b100
    } beat_t;

endpackage

>>> rtl/tccw_front.sv
// front end: cursor bookkeeping and decode of each character into a write command
module tccw_front
    import tccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_char,
    input  logic       queue_full,
    output logic       in_ready,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] floor_reg, floor_next;

    logic             accept;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic [ROW_W-1:0] row_adv;
    logic             gen;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign col_inc  = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W + 1)'(1);
    assign col_wrap = col_inc >= COLS_EXT;
    assign row_wrap = row_inc >= ROWS_EXT;
    assign row_adv  = row_wrap ? '0 : row_inc[ROW_W-1:0];

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        floor_next = floor_reg;
        gen        = 1'b0;

        push_cmd          = '0;
        push_cmd.ch       = in_char;
        push_cmd.attr     = ATTR_TEXT;
        push_cmd.row      = row_reg;
        push_cmd.col      = col_reg;
        push_cmd.cur_line = row_reg;

        unique case (in_char)
            CODE_BS:
            begin
                if (col_reg > floor_reg && col_reg != '0)
                begin
                    gen               = 1'b1;
                    col_next          = col_reg - COL_ONE;
                    push_cmd.ch       = CHAR_SPACE;
                    push_cmd.attr     = ATTR_BLANK;
                    push_cmd.col      = col_reg - COL_ONE;
                    push_cmd.cur_col  = col_reg - COL_ONE;
                    push_cmd.first    = 1'b1;
                end
            end
            CODE_NL:
            begin
                gen             = 1'b1;
                col_next        = COL_TWO;
                row_next        = row_adv;
                floor_next      = FLOOR_RESET;
                push_cmd.prompt = 1'b1;
                push_cmd.prow   = row_adv;
                push_cmd.pclr   = row_wrap;
            end
            default:
            begin
                gen            = 1'b1;
                push_cmd.first = 1'b1;
                if (!col_wrap)
                begin
                    col_next         = col_inc[COL_W-1:0];
                    push_cmd.cur_col = col_inc[COL_W-1:0];
                end
                else if (!row_wrap)
                begin
                    col_next          = '0;
                    row_next          = row_adv;
                    push_cmd.cur_col  = '0;
                    push_cmd.cur_line = row_adv;
                end
                else
                begin
                    // ran off the bottom: clear, home, and prompt on row 0
                    col_next          = COL_TWO;
                    row_next          = '0;
                    floor_next        = FLOOR_RESET;
                    push_cmd.cur_col  = '0;
                    push_cmd.cur_line = '0;
                    push_cmd.prompt   = 1'b1;
                    push_cmd.prow     = '0;
                    push_cmd.pclr     = 1'b1;
                end
            end
        endcase
    end

    assign push = accept && gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            floor_reg <= FLOOR_RESET;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            floor_reg <= floor_next;
        end
    end

endmodule

>>> rtl/tccw_fifo.sv
// short command queue between the front and back ends
module tccw_fifo
    import tccw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = cnt_reg == QCNT_W'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/tccw_back.sv
// back end: expands each command into one to three cell writes on the output stream
module tccw_back
    import tccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TDATA_W-1:0] out_data,
    output logic               out_last
);

    cmd_t               cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    beat_t              beat_reg, beat_next;
    logic               ovalid_reg, ovalid_next;
    logic [TDATA_W-1:0] odata_reg;
    logic               olast_reg;

    logic               emit;
    logic               is_last;
    logic [ROW_W-1:0]   b_row;
    logic [COL_W-1:0]   b_col;
    logic [7:0]         b_ch;
    logic [7:0]         b_attr;
    logic               b_clr;
    logic [COL_W-1:0]   b_ccol;
    logic [ROW_W-1:0]   b_cline;
    logic [CALC_W-1:0]  idx_full;
    logic [IDX_W-1:0]   b_idx;

    always_comb
    begin
        b_row   = cur_reg.row;
        b_col   = cur_reg.col;
        b_ch    = cur_reg.ch;
        b_attr  = cur_reg.attr;
        b_clr   = 1'b0;
        b_ccol  = cur_reg.cur_col;
        b_cline = cur_reg.cur_line;
        is_last = 1'b1;
        unique case (beat_reg)
            BEAT_MAIN:
            begin
                is_last = !cur_reg.prompt;
            end
            BEAT_GT:
            begin
                b_row   = cur_reg.prow;
                b_col   = '0;
                b_ch    = CHAR_PROMPT;
                b_attr  = ATTR_TEXT;
                b_clr   = cur_reg.pclr;
                b_ccol  = COL_ONE;
                b_cline = cur_reg.prow;
                is_last = 1'b0;
            end
            BEAT_SP:
            begin
                b_row   = cur_reg.prow;
                b_col   = COL_ONE;
                b_ch    = CHAR_SPACE;
                b_attr  = ATTR_TEXT;
                b_ccol  = COL_TWO;
                b_cline = cur_reg.prow;
            end
            default:
            begin
                is_last = 1'b1;
            end
        endcase
    end

    assign idx_full = CALC_W'(b_row) * CALC_W'(COLUMNS) + CALC_W'(b_col);
    assign b_idx    = idx_full[IDX_W-1:0];

    assign emit  = cur_valid_reg && (!ovalid_reg || out_ready);
    assign q_pop = q_valid && (!cur_valid_reg || (emit && is_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        beat_next      = beat_reg;
        if (q_pop)
        begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            beat_next      = q_cmd.first ? BEAT_MAIN : BEAT_GT;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                beat_next = (beat_reg == BEAT_MAIN) ? BEAT_GT : BEAT_SP;
            end
        end

        ovalid_next = ovalid_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= BEAT_MAIN;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            beat_reg      <= beat_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            odata_reg <= {b_cline, b_ccol, b_clr, b_attr, b_ch, b_idx};
            olast_reg <= is_last;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

>>> rtl/text_console_cursor_writer.sv
// top level of the text console cursor writer
//
// usage:
//   s_axis carries one character code per request in s_tdata; 8 is backspace,
//   10 is newline, every other code is printed with attribute 0x0f.
//   m_axis carries the screen cell writes that each character causes, one to
//   three per character (a backspace at the edit floor causes none); m_tlast
//   marks the final write belonging to one character.
// timing:
//   a character is decoded in the cycle it is taken and lands in a four-entry
//   command queue; the expander pops it into its command register once that
//   is free, and each write passes through the output register to m_axis.
//   while m_tready is high the expander issues one write per cycle, so a
//   character occupies the output for one to three writes; the front takes one
//   character per cycle while the queue has room.
// reset:
//   cursor goes to row 0, column 0, edit floor to column 2; queue and output
//   register are emptied.
// stalls:
//   when m_tready is low the output register holds, the expander waits, the
//   queue fills and s_tready drops once it is full.
module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // char_code
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // cell_index, cell_char, cell_attr, cleared,
                                          // cursor_col, cursor_line
    output logic               m_tlast
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    tccw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .queue_full (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tccw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    tccw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
